[rtl/tch_pkg.sv]
// Shared types, constants and helper functions for the tilt-compensated heading block.
// This file has no dependencies.
`default_nettype none
package tch_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int TAB_LEN             = 24;

    localparam logic signed [31:0] GAIN_Q30          = 32'sd652032874;
    localparam logic signed [23:0] RAD_PER_TENTH_Q32 = 24'sd7496132;
    localparam logic signed [29:0] CDEG_PER_RAD_Q16  = 30'sd375493621;

    localparam logic [2:0] REG_OFFSET_X = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z = 3'd2;
    localparam logic [2:0] REG_ROW_X    = 3'd3;
    localparam logic [2:0] REG_ROW_Y    = 3'd4;
    localparam logic [2:0] REG_ROW_Z    = 3'd5;
    localparam logic [2:0] REG_SIGN     = 3'd6;

    localparam logic [47:0] ROW_X_RESET = 48'h4000_0000_0000;
    localparam logic [47:0] ROW_Y_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROW_Z_RESET = 48'h0000_0000_4000;

    // Widths of the datapath words.
    localparam int TW  = 34; // sine/cosine Q30 lanes
    localparam int VW  = 52; // horizontal vector
    localparam int ZW  = 36; // angle accumulator

    function automatic logic [63:0] atan_q30(input int i);
        logic [63:0] t;
        case (i % TAB_LEN)
            0: t = 64'd843314857;   1: t = 64'd497837829;   2: t = 64'd263043837;
            3: t = 64'd133525159;   4: t = 64'd67021687;    5: t = 64'd33543516;
            6: t = 64'd16775851;    7: t = 64'd8388437;     8: t = 64'd4194283;
            9: t = 64'd2097149;     10: t = 64'd1048576;    11: t = 64'd524288;
            12: t = 64'd262144;     13: t = 64'd131072;     14: t = 64'd65536;
            15: t = 64'd32768;      16: t = 64'd16384;      17: t = 64'd8192;
            18: t = 64'd4096;       19: t = 64'd2048;       20: t = 64'd1024;
            21: t = 64'd512;        22: t = 64'd256;        default: t = 64'd128;
        endcase
        return t;
    endfunction

    // Arctangent of 2^-i in radians with fb fraction bits, rounded half up.
    function automatic logic signed [ZW-1:0] atan_tab(input int i, input int fb);
        logic [63:0] t;
        int s;
        t = atan_q30(i);
        s = 30 - fb;
        if (s > 0)
        begin
            t = (t + (64'd1 << (s - 1))) >> s;
        end
        else
        begin
            t = t << (-s);
        end
        return ZW'(t);
    endfunction

    typedef struct packed {
        logic               flip_r;
        logic               flip_p;
        logic signed [18:0] x1;
        logic signed [18:0] y1;
        logic signed [18:0] z1;
    } front_t;

endpackage
`default_nettype wire

[rtl/tch_rot_cell.sv]
// One CORDIC rotation step computing sine and cosine for roll and pitch together.
// Depends on tch_pkg.
`default_nettype none
module tch_rot_cell #(
    parameter int STEP = 0,
    parameter int FB   = tch_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          vin,
    input  wire logic signed [tch_pkg::TW-1:0] rx_in,
    input  wire logic signed [tch_pkg::TW-1:0] ry_in,
    input  wire logic signed [tch_pkg::ZW-1:0] rz_in,
    input  wire logic signed [tch_pkg::TW-1:0] px_in,
    input  wire logic signed [tch_pkg::TW-1:0] py_in,
    input  wire logic signed [tch_pkg::ZW-1:0] pz_in,
    input  wire tch_pkg::front_t               f_in,
    output logic                               vout,
    output logic signed [tch_pkg::TW-1:0]      rx_out,
    output logic signed [tch_pkg::TW-1:0]      ry_out,
    output logic signed [tch_pkg::ZW-1:0]      rz_out,
    output logic signed [tch_pkg::TW-1:0]      px_out,
    output logic signed [tch_pkg::TW-1:0]      py_out,
    output logic signed [tch_pkg::ZW-1:0]      pz_out,
    output tch_pkg::front_t                    f_out
);
    import tch_pkg::*;

    localparam logic signed [ZW-1:0] ANG = atan_tab(STEP, FB);

    logic vout_reg;
    logic signed [TW-1:0] rx_next, ry_next, px_next, py_next;
    logic signed [ZW-1:0] rz_next, pz_next;
    logic signed [TW-1:0] rx_reg, ry_reg, px_reg, py_reg;
    logic signed [ZW-1:0] rz_reg, pz_reg;
    front_t f_reg;

    always_comb
    begin
        if (!rz_in[ZW-1])
        begin
            rx_next = rx_in - (ry_in >>> STEP);
            ry_next = ry_in + (rx_in >>> STEP);
            rz_next = rz_in - ANG;
        end
        else
        begin
            rx_next = rx_in + (ry_in >>> STEP);
            ry_next = ry_in - (rx_in >>> STEP);
            rz_next = rz_in + ANG;
        end
        if (!pz_in[ZW-1])
        begin
            px_next = px_in - (py_in >>> STEP);
            py_next = py_in + (px_in >>> STEP);
            pz_next = pz_in - ANG;
        end
        else
        begin
            px_next = px_in + (py_in >>> STEP);
            py_next = py_in - (px_in >>> STEP);
            pz_next = pz_in + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            f_reg  <= f_in;
        end
    end

    assign vout   = vout_reg;
    assign rx_out = rx_reg;
    assign ry_out = ry_reg;
    assign rz_out = rz_reg;
    assign px_out = px_reg;
    assign py_out = py_reg;
    assign pz_out = pz_reg;
    assign f_out  = f_reg;

endmodule
`default_nettype wire

[rtl/tch_vec_cell.sv]
// One CORDIC vectoring step of the atan2 chain.
// Depends on tch_pkg.
`default_nettype none
module tch_vec_cell #(
    parameter int STEP = 0,
    parameter int FB   = tch_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          vin,
    input  wire logic signed [tch_pkg::VW-1:0] vx_in,
    input  wire logic signed [tch_pkg::VW-1:0] vy_in,
    input  wire logic signed [tch_pkg::ZW-1:0] z_in,
    input  wire logic [2:0]                    tag_in,
    output logic                               vout,
    output logic signed [tch_pkg::VW-1:0]      vx_out,
    output logic signed [tch_pkg::VW-1:0]      vy_out,
    output logic signed [tch_pkg::ZW-1:0]      z_out,
    output logic [2:0]                         tag_out
);
    import tch_pkg::*;

    localparam logic signed [ZW-1:0] ANG = atan_tab(STEP, FB);

    logic vout_reg;
    logic signed [VW-1:0] vx_next, vy_next, vx_reg, vy_reg;
    logic signed [ZW-1:0] z_next, z_reg;
    logic [2:0] tag_reg;

    always_comb
    begin
        if (vy_in > 0)
        begin
            vx_next = vx_in + (vy_in >>> STEP);
            vy_next = vy_in - (vx_in >>> STEP);
            z_next  = z_in + ANG;
        end
        else
        begin
            vx_next = vx_in - (vy_in >>> STEP);
            vy_next = vy_in + (vx_in >>> STEP);
            z_next  = z_in - ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign vout    = vout_reg;
    assign vx_out  = vx_reg;
    assign vy_out  = vy_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule
`default_nettype wire

[rtl/tilt_compensated_heading.sv]
// Top level of the tilt-compensated heading block: calibration, sine/cosine chain,
// tilt rotation, atan2 chain and output stage. Depends on tch_pkg, tch_rot_cell, tch_vec_cell.
//
// One magnetometer word (x, y, z, roll, pitch) goes in, one heading word in
// hundredths of a degree comes out. The block is a pipeline: a new word is taken
// every cycle while the output is not stalled, and each word's result passes through
// the two chains of CORDIC cells and the single stages A to G around them. When the
// output is stalled the whole pipeline holds. Configuration words are written by index;
// the user must write them only while no word is in flight; the block does not enforce it.
`default_nettype none
module tilt_compensated_heading #(
    parameter int CORDIC_STEPS    = tch_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = tch_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bits 15:0 mag_x, 31:16 mag_y, 47:32 mag_z, 59:48 roll_tenths,
    // 71:60 pitch_tenths, 79:72 zero
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // bits 15:0 heading_centideg
    output logic [15:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import tch_pkg::*;

    localparam int NS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam int FB = ANGLE_FRAC_BITS;

    // Pipeline advances whenever the output slot is free or being taken.
    logic en;
    logic out_v_reg;
    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // Configuration registers.
    logic [15:0] off_x_reg, off_y_reg, off_z_reg;
    logic [47:0] row_x_reg, row_y_reg, row_z_reg;
    logic [3:0]  sign_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
            row_x_reg <= ROW_X_RESET;
            row_y_reg <= ROW_Y_RESET;
            row_z_reg <= ROW_Z_RESET;
            sign_reg  <= 4'hF;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OFFSET_X: off_x_reg <= cfg_data[15:0];
                REG_OFFSET_Y: off_y_reg <= cfg_data[15:0];
                REG_OFFSET_Z: off_z_reg <= cfg_data[15:0];
                REG_ROW_X:    row_x_reg <= cfg_data;
                REG_ROW_Y:    row_y_reg <= cfg_data;
                REG_ROW_Z:    row_z_reg <= cfg_data;
                REG_SIGN:     sign_reg  <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // Stage A: offsets and the nine matrix products.
    logic                 a_v_reg;
    logic signed [15:0]   xo, yo, zo;
    logic signed [11:0]   a_roll_reg, a_pitch_reg;
    logic signed [31:0]   prod_reg [9];
    logic signed [31:0]   prod_next [9];
    logic signed [15:0]   coef [9];

    assign xo = $signed(s_axis_tdata[15:0] - off_x_reg);
    assign yo = $signed(s_axis_tdata[31:16] - off_y_reg);
    assign zo = $signed(s_axis_tdata[47:32] - off_z_reg);

    always_comb
    begin
        coef[0] = $signed(row_x_reg[47:32]);
        coef[1] = $signed(row_x_reg[31:16]);
        coef[2] = $signed(row_x_reg[15:0]);
        coef[3] = $signed(row_y_reg[47:32]);
        coef[4] = $signed(row_y_reg[31:16]);
        coef[5] = $signed(row_y_reg[15:0]);
        coef[6] = $signed(row_z_reg[47:32]);
        coef[7] = $signed(row_z_reg[31:16]);
        coef[8] = $signed(row_z_reg[15:0]);
        for (int k = 0; k < 3; k++)
        begin
            prod_next[3*k]   = coef[3*k] * xo;
            prod_next[3*k+1] = coef[3*k+1] * yo;
            prod_next[3*k+2] = coef[3*k+2] * zo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            a_roll_reg  <= $signed(s_axis_tdata[59:48]);
            a_pitch_reg <= $signed(s_axis_tdata[71:60]);
        end
    end

    // Stage B: sums, truncation, saturation, sign selection, angle folding
    // and radian conversion.
    function automatic logic signed [18:0] row_sat(input logic signed [33:0] s);
        logic signed [33:0] q;
        q = (s < 0) ? -((-s) >>> 14) : (s >>> 14);
        if (q > 34'sd32767)
        begin
            return 19'sd32767;
        end
        else if (q < -34'sd32768)
        begin
            return -19'sd32768;
        end
        return 19'(q);
    endfunction

    function automatic logic signed [ZW-1:0] to_rad(input logic signed [12:0] t, input int fb);
        logic signed [39:0] p;
        logic [39:0] m;
        int s;
        p = t * RAD_PER_TENTH_Q32;
        m = p[39] ? 40'(-p) : 40'(p);
        s = 32 - fb;
        m = (m + (40'd1 << (s - 1))) >> s;
        return p[39] ? -ZW'(m) : ZW'(m);
    endfunction

    logic               b_v_reg;
    front_t             b_f_reg, b_f_next;
    logic signed [ZW-1:0] b_rz_reg, b_pz_reg, b_rz_next, b_pz_next;
    logic signed [33:0] sx, sy, sz;
    logic signed [12:0] rl, pt;

    always_comb
    begin
        sx = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]);
        sy = 34'(prod_reg[3]) + 34'(prod_reg[4]) + 34'(prod_reg[5]);
        sz = 34'(prod_reg[6]) + 34'(prod_reg[7]) + 34'(prod_reg[8]);
        b_f_next.x1 = row_sat(sx);
        b_f_next.y1 = sign_reg[0] ? -row_sat(sy) : row_sat(sy);
        b_f_next.z1 = sign_reg[1] ? -row_sat(sz) : row_sat(sz);
        rl = sign_reg[2] ? -13'(a_roll_reg) : 13'(a_roll_reg);
        pt = sign_reg[3] ? -13'(a_pitch_reg) : 13'(a_pitch_reg);
        b_f_next.flip_r = (rl > 13'sd900) || (rl < -13'sd900);
        b_f_next.flip_p = (pt > 13'sd900) || (pt < -13'sd900);
        if (rl > 13'sd900)
        begin
            rl = rl - 13'sd1800;
        end
        else if (rl < -13'sd900)
        begin
            rl = rl + 13'sd1800;
        end
        if (pt > 13'sd900)
        begin
            pt = pt - 13'sd1800;
        end
        else if (pt < -13'sd900)
        begin
            pt = pt + 13'sd1800;
        end
        b_rz_next = to_rad(rl, FB);
        b_pz_next = to_rad(pt, FB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_f_reg  <= b_f_next;
            b_rz_reg <= b_rz_next;
            b_pz_reg <= b_pz_next;
        end
    end

    // Rotation chain.
    logic                 rv [NS+1];
    logic signed [TW-1:0] rx [NS+1];
    logic signed [TW-1:0] ry [NS+1];
    logic signed [ZW-1:0] rz [NS+1];
    logic signed [TW-1:0] px [NS+1];
    logic signed [TW-1:0] py [NS+1];
    logic signed [ZW-1:0] pz [NS+1];
    front_t               rf [NS+1];

    assign rv[0] = b_v_reg;
    assign rx[0] = TW'(GAIN_Q30);
    assign ry[0] = '0;
    assign rz[0] = b_rz_reg;
    assign px[0] = TW'(GAIN_Q30);
    assign py[0] = '0;
    assign pz[0] = b_pz_reg;
    assign rf[0] = b_f_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_rot
        tch_rot_cell #(.STEP(g), .FB(FB)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .vin(rv[g]),
            .rx_in(rx[g]), .ry_in(ry[g]), .rz_in(rz[g]),
            .px_in(px[g]), .py_in(py[g]), .pz_in(pz[g]), .f_in(rf[g]),
            .vout(rv[g+1]),
            .rx_out(rx[g+1]), .ry_out(ry[g+1]), .rz_out(rz[g+1]),
            .px_out(px[g+1]), .py_out(py[g+1]), .pz_out(pz[g+1]), .f_out(rf[g+1])
        );
    end

    // Stage C: final sine/cosine and sr*sp, cr*sp products.
    function automatic logic signed [TW-1:0] rnd30(input logic signed [67:0] p);
        logic [67:0] m;
        m = p[67] ? 68'(-p) : 68'(p);
        m = (m + (68'd1 << 29)) >> 30;
        return p[67] ? -TW'(m) : TW'(m);
    endfunction

    logic                 c_v_reg;
    logic signed [TW-1:0] sr, cr, sp, cp;
    logic signed [67:0]   srsp_p_reg, crsp_p_reg;
    logic signed [TW-1:0] c_sr_reg, c_cr_reg, c_cp_reg;
    front_t               c_f_reg;

    assign sr = rf[NS].flip_r ? -ry[NS] : ry[NS];
    assign cr = rf[NS].flip_r ? -rx[NS] : rx[NS];
    assign sp = rf[NS].flip_p ? -py[NS] : py[NS];
    assign cp = rf[NS].flip_p ? -px[NS] : px[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= rv[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srsp_p_reg <= 68'(sr) * 68'(sp);
            crsp_p_reg <= 68'(cr) * 68'(sp);
            c_sr_reg   <= sr;
            c_cr_reg   <= cr;
            c_cp_reg   <= cp;
            c_f_reg    <= rf[NS];
        end
    end

    // Stage D: five products into the horizontal plane.
    logic                 d_v_reg;
    logic signed [VW-1:0] d_t0_reg, d_t1_reg, d_t2_reg, d_t3_reg, d_t4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_t0_reg <= VW'(c_f_reg.x1) * VW'(c_cp_reg);
            d_t1_reg <= VW'(c_f_reg.y1) * VW'(rnd30(srsp_p_reg));
            d_t2_reg <= VW'(c_f_reg.z1) * VW'(rnd30(crsp_p_reg));
            d_t3_reg <= VW'(c_f_reg.y1) * VW'(c_cr_reg);
            d_t4_reg <= VW'(c_f_reg.z1) * VW'(c_sr_reg);
        end
    end

    // Stage E: sums, special cases, quadrant fold into the vectoring chain.
    logic                 e_v_reg;
    logic signed [VW-1:0] e_vx_reg, e_vy_reg, xh, yh;
    logic [2:0]           e_tag_reg, e_tag_next;

    // Tags of the fixed headings.
    localparam logic [2:0] TAG_X0_YNEG = 3'b001;
    localparam logic [2:0] TAG_X0_YPOS = 3'b011;
    localparam logic [2:0] TAG_Y0_XPOS = 3'b101;
    localparam logic [2:0] TAG_Y0_XNEG = 3'b111;

    // tag: bit0 special result, bit1 x negative, bit2 y non-negative
    // (for special results bit2:1 selects 9000/27000/0/18000).
    always_comb
    begin
        xh = d_t0_reg + d_t1_reg - d_t2_reg;
        yh = d_t3_reg + d_t4_reg;
        if (xh == 0)
        begin
            e_tag_next = (yh > 0) ? TAG_X0_YPOS : TAG_X0_YNEG;
        end
        else if (yh == 0)
        begin
            e_tag_next = xh[VW-1] ? TAG_Y0_XNEG : TAG_Y0_XPOS;
        end
        else
        begin
            e_tag_next = {(yh >= 0), xh[VW-1], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_vx_reg  <= xh[VW-1] ? -xh : xh;
            e_vy_reg  <= xh[VW-1] ? -yh : yh;
            e_tag_reg <= e_tag_next;
        end
    end

    // Vectoring chain.
    logic                 vv [NS+1];
    logic signed [VW-1:0] vx [NS+1];
    logic signed [VW-1:0] vy [NS+1];
    logic signed [ZW-1:0] vz [NS+1];
    logic [2:0]           vt [NS+1];

    assign vv[0] = e_v_reg;
    assign vx[0] = e_vx_reg;
    assign vy[0] = e_vy_reg;
    assign vz[0] = '0;
    assign vt[0] = e_tag_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_vec
        tch_vec_cell #(.STEP(g), .FB(FB)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .vin(vv[g]),
            .vx_in(vx[g]), .vy_in(vy[g]), .z_in(vz[g]), .tag_in(vt[g]),
            .vout(vv[g+1]), .vx_out(vx[g+1]), .vy_out(vy[g+1]),
            .z_out(vz[g+1]), .tag_out(vt[g+1])
        );
    end

    // Stage F: scale to centidegrees.
    logic               f_v_reg;
    logic signed [67:0] f_p_reg;
    logic [2:0]         f_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= vv[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_p_reg   <= 68'(vz[NS]) * 68'(CDEG_PER_RAD_Q16);
            f_tag_reg <= vt[NS];
        end
    end

    // Stage G: round, quadrant offset, clamp, output register.
    logic [67:0]        g_m;
    logic signed [31:0] g_r;
    logic [15:0]        out_d_reg;
    logic [15:0]        head_next;

    always_comb
    begin
        g_m = f_p_reg[67] ? 68'(-f_p_reg) : 68'(f_p_reg);
        g_m = (g_m + (68'd1 << (15 + FB))) >> (16 + FB);
        g_r = f_p_reg[67] ? -32'(g_m) : 32'(g_m);
        if (f_tag_reg[1])
        begin
            g_r = g_r + (f_tag_reg[2] ? 32'sd18000 : -32'sd18000);
        end
        if (g_r > 32'sd18000)
        begin
            g_r = 32'sd18000;
        end
        if (g_r < -32'sd18000)
        begin
            g_r = -32'sd18000;
        end
        case (f_tag_reg)
            TAG_X0_YNEG: head_next = 16'd9000;
            TAG_X0_YPOS: head_next = 16'd27000;
            TAG_Y0_XPOS: head_next = 16'd0;
            TAG_Y0_XNEG: head_next = 16'd18000;
            default:     head_next = g_r[15:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_d_reg <= head_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled heading changed");

    // While the output stalls the pipeline takes no new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted during stall");

    // A delivered heading lies in its documented range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd18000 || m_axis_tdata == 16'd27000))
        else $error("heading out of range");

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for tilt_compensated_heading: drives magnetometer words
// and configuration writes, predicts or looks up each heading and checks the output
// stream in order. Depends on tch_pkg and the RTL of tilt_compensated_heading.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tch_pkg::*;

    localparam int STEPS = 16;
    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 2 * STEPS + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam longint ARCTAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [47:0] cfg_data;

    // Shadow copy of the block's registers.
    logic [15:0] cal_off_x, cal_off_y, cal_off_z;
    logic [47:0] cal_row_x, cal_row_y, cal_row_z;
    logic [3:0] cal_sign;

    logic [15:0] heading_queue [$];
    int mismatches;
    int headings_seen;
    int words_sent;
    int cycles;
    bit idling_on;
    bit long_hold_req;

    tilt_compensated_heading uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic longint round_shift(input longint v, input int s);
        longint m;
        if (s == 0)
        begin
            return v;
        end
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint arctan_step(input int i);
        return round_shift(ARCTAN_Q30[i % 24], 30 - FRAC);
    endfunction

    function automatic longint calibrate_axis(input logic [47:0] row, input longint x,
                                              input longint y, input longint z);
        longint c0, c1, c2, s;
        c0 = $signed(row[47:32]);
        c1 = $signed(row[31:16]);
        c2 = $signed(row[15:0]);
        s = (c0 * x + c1 * y + c2 * z) / 16384;
        if (s > 32767)
        begin
            s = 32767;
        end
        if (s < -32768)
        begin
            s = -32768;
        end
        return s;
    endfunction

    // Sine and cosine in Q30 of an angle given in tenths of a degree.
    function automatic void tilt_sin_cos(input longint t, output longint sn,
                                         output longint cs);
        bit flip;
        longint x, y, z, nx;
        flip = 1'b0;
        x = GAIN_Q30;
        y = 0;
        if (t > 900)
        begin
            t -= 1800;
            flip = 1'b1;
        end
        else if (t < -900)
        begin
            t += 1800;
            flip = 1'b1;
        end
        z = round_shift(t * RAD_PER_TENTH_Q32, 32 - FRAC);
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic longint bearing_cdeg(input longint y, input longint x);
        longint vx, vy, z, nx, r;
        vx = x;
        vy = y;
        z = 0;
        if (x < 0)
        begin
            vx = -x;
            vy = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (vy > 0)
            begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                z += arctan_step(i);
            end
            else
            begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                z -= arctan_step(i);
            end
            vx = nx;
        end
        r = round_shift(z * CDEG_PER_RAD_Q16, 16 + FRAC);
        if (x < 0)
        begin
            r += (y >= 0) ? 18000 : -18000;
        end
        if (r > 18000)
        begin
            r = 18000;
        end
        if (r < -18000)
        begin
            r = -18000;
        end
        return r;
    endfunction

    function automatic logic [15:0] predict_heading(input logic [79:0] w);
        logic [15:0] dx, dy, dz;
        longint xo, yo, zo, roll, pitch, x1, y1, z1;
        longint sr, cr, sp, cp, srsp, crsp, xh, yh, h;
        dx = w[15:0] - cal_off_x;
        dy = w[31:16] - cal_off_y;
        dz = w[47:32] - cal_off_z;
        xo = $signed(dx);
        yo = $signed(dy);
        zo = $signed(dz);
        roll = $signed(w[59:48]);
        pitch = $signed(w[71:60]);
        x1 = calibrate_axis(cal_row_x, xo, yo, zo);
        y1 = calibrate_axis(cal_row_y, xo, yo, zo);
        z1 = calibrate_axis(cal_row_z, xo, yo, zo);
        if (cal_sign[0]) y1 = -y1;
        if (cal_sign[1]) z1 = -z1;
        if (cal_sign[2]) roll = -roll;
        if (cal_sign[3]) pitch = -pitch;
        tilt_sin_cos(roll, sr, cr);
        tilt_sin_cos(pitch, sp, cp);
        srsp = round_shift(sr * sp, 30);
        crsp = round_shift(cr * sp, 30);
        xh = x1 * cp + y1 * srsp - z1 * crsp;
        yh = y1 * cr + z1 * sr;
        if (xh == 0)
        begin
            h = (yh <= 0) ? 9000 : 27000;
        end
        else if (yh == 0)
        begin
            h = (xh > 0) ? 0 : 18000;
        end
        else
        begin
            h = bearing_cdeg(yh, xh);
        end
        return h[15:0];
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("Mismatch at cycle %0d: %s got %0d expected %0d", cycles, what,
                 $signed(got), $signed(want));
        mismatches++;
    endtask

    // Output side: random stalls, one long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            headings_seen++;
            if (heading_queue.size() == 0)
            begin
                report("unexpected word", m_axis_tdata, 16'd0);
            end
            else
            begin
                if (m_axis_tdata !== heading_queue[0])
                begin
                    report("heading_centideg", m_axis_tdata, heading_queue[0]);
                end
                void'(heading_queue.pop_front());
            end
        end
    end

    task automatic send_reading(input logic [79:0] w, input bit fixed, input logic [15:0] h);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge clk); while (!s_axis_tready);
        heading_queue.push_back(fixed ? h : predict_heading(w));
        words_sent++;
    endtask

    function automatic logic [79:0] pack_reading(input logic [15:0] x, input logic [15:0] y,
                                                 input logic [15:0] z, input logic [11:0] r,
                                                 input logic [11:0] p);
        return {8'd0, p, r, z, y, x};
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] v);
        while (heading_queue.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OFFSET_X: cal_off_x = v[15:0];
            REG_OFFSET_Y: cal_off_y = v[15:0];
            REG_OFFSET_Z: cal_off_z = v[15:0];
            REG_ROW_X: cal_row_x = v;
            REG_ROW_Y: cal_row_y = v;
            REG_ROW_Z: cal_row_z = v;
            REG_SIGN: cal_sign = v[3:0];
            default: ;
        endcase
    endtask

    function automatic logic [47:0] random_row();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        if ($urandom_range(0, 1))
        begin
            // Coefficients within +-1.0 keep most products away from saturation.
            v[47:32] = 16'($urandom_range(0, 32768) - 16384);
            v[31:16] = 16'($urandom_range(0, 32768) - 16384);
            v[15:0] = 16'($urandom_range(0, 32768) - 16384);
        end
        return v;
    endfunction

    function automatic logic [79:0] random_reading();
        logic [15:0] x, y, z;
        logic [11:0] r, p;
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        r = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3600) - 1800);
        p = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3600) - 1800);
        if ($urandom_range(0, 9) == 0) x = 16'd0;
        if ($urandom_range(0, 9) == 0) y = 16'd0;
        if ($urandom_range(0, 9) == 0) z = 16'd0;
        return pack_reading(x, y, z, r, p);
    endfunction

    typedef struct {
        logic [15:0] x, y, z;
        logic [11:0] r, p;
        bit fixed;
        logic [15:0] h;
    } reading_row_t;

    reading_row_t plan [20];

    initial
    begin
        logic [47:0] row_sat;
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_OFFSET_X;
        cfg_data <= '0;
        cal_off_x = '0;
        cal_off_y = '0;
        cal_off_z = '0;
        cal_row_x = ROW_X_RESET;
        cal_row_y = ROW_Y_RESET;
        cal_row_z = ROW_Z_RESET;
        cal_sign = 4'hF;
        mismatches = 0;
        headings_seen = 0;
        words_sent = 0;
        idling_on = 1'b1;
        long_hold_req = 1'b0;
        plan = '{
            '{16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 1'b1, 16'd9000},
            '{16'd1000, 16'd0, 16'd0, 12'd0, 12'd0, 1'b1, 16'd0},
            '{-16'sd1000, 16'd0, 16'd0, 12'd0, 12'd0, 1'b1, 16'd18000},
            '{16'd0, 16'd0, 16'd0, 12'd1800, -12'sd1800, 1'b1, 16'd9000},
            '{16'd0, 16'd1000, 16'd0, 12'd0, 12'd0, 1'b0, 16'd0},
            '{16'd0, -16'sd1000, 16'd0, 12'd0, 12'd0, 1'b0, 16'd0},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd0, 12'd0, 1'b0, 16'd0},
            '{16'h8000, 16'h8000, 16'h8000, 12'd0, 12'd0, 1'b0, 16'd0},
            '{16'h8000, 16'h7FFF, 16'h8000, 12'd1800, 12'd1800, 1'b0, 16'd0},
            '{16'h7FFF, 16'h8000, 16'h7FFF, -12'sd1800, -12'sd1800, 1'b0, 16'd0},
            '{16'd500, 16'd300, -16'sd200, 12'h7FF, 12'h800, 1'b0, 16'd0},
            '{-16'sd500, 16'd300, 16'd200, 12'h800, 12'h7FF, 1'b0, 16'd0},
            '{16'd300, 16'd400, 16'd500, 12'd900, -12'sd900, 1'b0, 16'd0},
            '{16'd300, 16'd400, 16'd500, 12'd901, -12'sd901, 1'b0, 16'd0},
            '{-16'sd300, -16'sd400, 16'd500, -12'sd899, 12'd899, 1'b0, 16'd0},
            '{16'd1, 16'd1, 16'd1, 12'd450, 12'd300, 1'b0, 16'd0},
            '{16'hFFFF, 16'd0, 16'd1, 12'd0, 12'd1, 1'b0, 16'd0},
            '{16'd0, 16'd0, 16'd1000, 12'd300, 12'd200, 1'b0, 16'd0},
            '{16'd0, 16'd1000, 16'd1000, 12'd1200, -12'sd1500, 1'b0, 16'd0},
            '{16'h5555, 16'hAAAA, 16'h5555, 12'hAAA, 12'h555, 1'b0, 16'd0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_reading(pack_reading(plan[i].x, plan[i].y, plan[i].z, plan[i].r, plan[i].p),
                         plan[i].fixed, plan[i].h);
        end
        s_axis_tvalid <= 1'b0;

        // Six phases of random words, each under its own register setting.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_SIGN, 48'd0);
                    write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
                end
                1:
                begin
                    write_reg(REG_OFFSET_X, 48'h7FFF);
                    write_reg(REG_OFFSET_Y, 48'h8000);
                    write_reg(REG_OFFSET_Z, 48'h7FFF);
                    write_reg(REG_SIGN, 48'd15);
                end
                2:
                begin
                    row_sat = 48'h7FFF_7FFF_7FFF;
                    write_reg(REG_ROW_X, row_sat);
                    write_reg(REG_ROW_Y, 48'h8000_8000_8000);
                    write_reg(REG_ROW_Z, 48'h7FFF_8000_0000);
                    write_reg(REG_OFFSET_X, 48'h8000);
                    write_reg(REG_SIGN, 48'd5);
                end
                default:
                begin
                    write_reg(REG_OFFSET_X, 48'($urandom));
                    write_reg(REG_OFFSET_Y, 48'($urandom));
                    write_reg(REG_OFFSET_Z, 48'($urandom));
                    write_reg(REG_ROW_X, random_row());
                    write_reg(REG_ROW_Y, random_row());
                    write_reg(REG_ROW_Z, random_row());
                    write_reg(REG_SIGN, 48'($urandom_range(0, 15)));
                end
            endcase
            if (phase == 5)
            begin
                idling_on = 1'b0;
            end
            for (int n = 0; n < 247; n++)
            begin
                if (phase == 3 && n == 20)
                begin
                    long_hold_req = 1'b1;
                end
                send_reading(random_reading(), 1'b0, 16'd0);
            end
            s_axis_tvalid <= 1'b0;
        end

        while (heading_queue.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        $display("Sent %0d magnetometer words over seven register settings, %0d headings checked",
                 words_sent, headings_seen);
        $display("Covered offset wrap, matrix saturation, several sign selections and full angle codes");
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/tch_pkg.sv
rtl/tch_rot_cell.sv
rtl/tch_vec_cell.sv
rtl/tilt_compensated_heading.sv
sim/tb.sv
